FILE: design/qrn_pkg.sv
// Shared types, constants and the control program of the Q16.16 reciprocal unit.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`default_nettype none
package qrn_pkg;

  localparam int MAX_ITERATIONS = 16;
  localparam int N_W            = $clog2(MAX_ITERATIONS + 1);
  typedef logic [N_W-1:0] iter_t;

  localparam logic [31:0] Q_TWO        = 32'h0002_0000;
  localparam logic [31:0] Q_48_OVER_17 = 32'd185043;
  localparam logic [31:0] Q_32_OVER_17 = 32'd123362;
  localparam logic [15:0] TOL_RESET    = 16'd66;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_ZCHK  = 4'd2;
  localparam logic [3:0] OP_NORM  = 4'd3;
  localparam logic [3:0] OP_GMUL  = 4'd4;
  localparam logic [3:0] OP_GUESS = 4'd5;
  localparam logic [3:0] OP_MDX   = 4'd6;
  localparam logic [3:0] OP_SUB   = 4'd7;
  localparam logic [3:0] OP_MTX   = 4'd8;
  localparam logic [3:0] OP_UPD   = 4'd9;
  localparam logic [3:0] OP_OUT   = 4'd10;

  // sequencing
  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_JUMP     = 3'd1;
  localparam logic [2:0] SEQ_IF_ZERO  = 3'd2;
  localparam logic [2:0] SEQ_LOOP     = 3'd3;
  localparam logic [2:0] SEQ_WAIT_IN  = 3'd4;
  localparam logic [2:0] SEQ_WAIT_OUT = 3'd5;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT = 4'd0;
  localparam pc_t PC_ZCHK = 4'd1;
  localparam pc_t PC_N16  = 4'd2;
  localparam pc_t PC_N8   = 4'd3;
  localparam pc_t PC_N4   = 4'd4;
  localparam pc_t PC_N2   = 4'd5;
  localparam pc_t PC_N1   = 4'd6;
  localparam pc_t PC_GMUL = 4'd7;
  localparam pc_t PC_GESS = 4'd8;
  localparam pc_t PC_MDX  = 4'd9;
  localparam pc_t PC_SUB  = 4'd10;
  localparam pc_t PC_MTX  = 4'd11;
  localparam pc_t PC_UPD  = 4'd12;
  localparam pc_t PC_DONE = 4'd13;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] seq;
    pc_t        target;
    logic [4:0] sh;
  } uword_t;

  typedef struct packed {
    logic [3:0] op;
    logic       fire;
  } dp_ctl_t;

  typedef struct packed {
    logic zero;
    logic stop;
  } dp_stat_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, seq: SEQ_JUMP, target: PC_WAIT, sh: 5'd0};
    unique case (pc)
      PC_WAIT: w = '{op: OP_LOAD,  seq: SEQ_WAIT_IN,  target: PC_WAIT, sh: 5'd0};
      PC_ZCHK: w = '{op: OP_ZCHK,  seq: SEQ_IF_ZERO,  target: PC_DONE, sh: 5'd0};
      PC_N16:  w = '{op: OP_NORM,  seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd16};
      PC_N8:   w = '{op: OP_NORM,  seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd8};
      PC_N4:   w = '{op: OP_NORM,  seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd4};
      PC_N2:   w = '{op: OP_NORM,  seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd2};
      PC_N1:   w = '{op: OP_NORM,  seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd1};
      PC_GMUL: w = '{op: OP_GMUL,  seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd0};
      PC_GESS: w = '{op: OP_GUESS, seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd0};
      PC_MDX:  w = '{op: OP_MDX,   seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd0};
      PC_SUB:  w = '{op: OP_SUB,   seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd0};
      PC_MTX:  w = '{op: OP_MTX,   seq: SEQ_NEXT,     target: PC_WAIT, sh: 5'd0};
      PC_UPD:  w = '{op: OP_UPD,   seq: SEQ_LOOP,     target: PC_MDX,  sh: 5'd0};
      PC_DONE: w = '{op: OP_OUT,   seq: SEQ_WAIT_OUT, target: PC_WAIT, sh: 5'd0};
      default: w = '{op: OP_NOP,   seq: SEQ_JUMP,     target: PC_WAIT, sh: 5'd0};
    endcase
    return w;
  endfunction

  // iterations field saturates at 31
  function automatic logic [4:0] iter_sat(input iter_t n);
    if (N_W > 5 && int'(n) > 31) return 5'd31;
    return 5'(n);
  endfunction

endpackage
`default_nettype wire

FILE: design/qrn_sequencer.sv
// Step counter and control-word ROM of the reciprocal unit.
// Depends on qrn_pkg (program table, op and sequencing codes).
`default_nettype none
module qrn_sequencer
  import qrn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     out_free,
  input  wire dp_stat_t stat,
  output dp_ctl_t       ctl,
  output logic [4:0]    sh,
  output logic          in_ready,
  output logic          out_load
);

  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   fire;

  assign uw = ucode(pc_r);

  always_comb begin
    case (uw.seq)
      SEQ_WAIT_IN:  fire = in_valid;
      SEQ_WAIT_OUT: fire = out_free;
      default:      fire = 1'b1;
    endcase
  end

  always_comb begin
    unique case (uw.seq)
      SEQ_NEXT:     pc_nxt = pc_r + pc_t'(1);
      SEQ_JUMP:     pc_nxt = uw.target;
      SEQ_IF_ZERO:  pc_nxt = stat.zero ? uw.target : pc_r + pc_t'(1);
      SEQ_LOOP:     pc_nxt = stat.stop ? pc_r + pc_t'(1) : uw.target;
      SEQ_WAIT_IN:  pc_nxt = in_valid ? pc_r + pc_t'(1) : pc_r;
      SEQ_WAIT_OUT: pc_nxt = out_free ? uw.target : pc_r;
      default:      pc_nxt = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.op   = uw.op;
  assign ctl.fire = fire;
  assign sh       = uw.sh;
  assign in_ready = (uw.seq == SEQ_WAIT_IN);
  assign out_load = (uw.op == OP_OUT) && fire;

endmodule
`default_nettype wire

FILE: design/qrn_datapath.sv
// Datapath: normalizer, shared 32x32 multiplier with registered product, estimate
// and convergence logic. Depends on qrn_pkg; steered by qrn_sequencer.
`default_nettype none
module qrn_datapath
  import qrn_pkg::*;
(
  input  wire logic        clk,
  input  wire dp_ctl_t     ctl,
  input  wire logic [4:0]  sh,
  input  wire logic [31:0] divisor,
  input  wire logic [15:0] tol,
  output dp_stat_t         stat,
  output logic [31:0]      recip,
  output iter_t            iters,
  output logic [1:0]       status
);

  logic [31:0] d_r, nv_r, x_r, t_r, pq_r;
  logic [4:0]  z_r;
  iter_t       n_r;
  logic [1:0]  st_r;

  logic [31:0] mul_a, mul_b, est, guess, diff, dsum;
  logic [63:0] prod;
  logic        conv, top_zero;

  always_comb begin
    case (ctl.op)
      OP_GMUL: begin
        mul_a = {16'd0, nv_r[31:16]};
        mul_b = Q_32_OVER_17;
      end
      OP_MTX: begin
        mul_a = t_r;
        mul_b = x_r;
      end
      default: begin
        mul_a = d_r;
        mul_b = x_r;
      end
    endcase
  end

  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign top_zero = (nv_r >> (6'd32 - 6'(sh))) == 32'd0;
  assign est      = Q_48_OVER_17 - pq_r;
  assign guess    = z_r[4] ? (est >> z_r[3:0]) : (est << (5'd16 - z_r));
  assign diff     = pq_r - x_r;
  assign dsum     = diff + {16'd0, tol};
  assign conv     = dsum <= {15'd0, tol, 1'b0};

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      case (ctl.op)
        OP_LOAD: begin
          d_r  <= divisor;
          nv_r <= divisor;
          z_r  <= 5'd0;
          n_r  <= '0;
        end
        OP_ZCHK: begin
          if (d_r == 32'd0) begin
            x_r  <= 32'hFFFF_FFFF;
            st_r <= ST_ZERO;
          end
        end
        OP_NORM: begin
          if (top_zero) begin
            nv_r <= nv_r << sh;
            z_r  <= z_r + sh;
          end
        end
        OP_GMUL, OP_MDX, OP_MTX: pq_r <= prod[47:16];
        OP_GUESS: x_r <= guess;
        OP_SUB:   t_r <= Q_TWO - pq_r;
        OP_UPD: begin
          x_r  <= pq_r;
          n_r  <= n_r + iter_t'(1);
          st_r <= conv ? ST_CONV : ST_LIMIT;
        end
        default: ;
      endcase
    end
  end

  assign stat.zero = (d_r == 32'd0);
  assign stat.stop = conv || (n_r == iter_t'(MAX_ITERATIONS - 1));
  assign recip     = x_r;
  assign iters     = n_r;
  assign status    = st_r;

endmodule
`default_nettype wire

FILE: design/q16_reciprocal_newton.sv
// A request runs N Newton steps (N = 1..MAX_ITERATIONS), none for a zero divisor. Each step
// is four microcode steps around the one shared 32x32 multiplier; normalization takes five
// steps. One request at a time: the next is taken the cycle after the result has entered
// the output register, so a new divisor is never taken while one is still in work.
// Reset (rst_n low, synchronous) idles the sequencer, empties the output register, tol 66.
`default_nettype none
module q16_reciprocal_newton
  import qrn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,    // tolerance
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] divisor
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [31:0] reciprocal, [36:32] iterations, rest 0
  output logic [1:0]       out_tuser    // [1:0] status
);

  logic [15:0] tol_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_recip_r;
  logic [4:0]  out_iter_r;
  logic [1:0]  out_st_r;

  dp_ctl_t     ctl;
  dp_stat_t    stat;
  logic        out_free, out_load;
  logic [31:0] recip;
  iter_t       iters;
  logic [1:0]  status;
  logic [4:0]  sh;

  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  qrn_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl),
    .sh       (sh),
    .in_ready (in_tready),
    .out_load (out_load)
  );

  qrn_datapath u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .sh      (sh),
    .divisor (in_tdata),
    .tol     (tol_r),
    .stat    (stat),
    .recip   (recip),
    .iters   (iters),
    .status  (status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) tol_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_recip_r <= recip;
      out_iter_r  <= iter_sat(iters);
      out_st_r    <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_iter_r, out_recip_r};
  assign out_tuser  = out_st_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer still ready after taking a request");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status == ST_ZERO) |-> (recip == 32'hFFFF_FFFF && iters == '0))
    else $error("zero divisor result malformed");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status == ST_LIMIT) |-> (iters == iter_t'(MAX_ITERATIONS)))
    else $error("iteration limit flagged at wrong count");

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status == ST_CONV) |-> (iters != '0))
    else $error("converged with no Newton step");

endmodule
`default_nettype wire

FILE: tb/sv/q16_reciprocal_newton_tb.sv
// Self-checking testbench for q16_reciprocal_newton: directed table, then random divisors
// under several tolerance settings. Depends on qrn_pkg and the q16_reciprocal_newton RTL.
module q16_reciprocal_newton_tb;
  import qrn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 200;
  localparam int N_PHASES    = 6;
  localparam int N_ROWS      = 22;

  typedef struct packed {
    logic [31:0] divisor;
    logic [31:0] recip;
    logic [4:0]  iters;
    logic [1:0]  status;
  } recip_res_t;

  typedef struct packed {
    logic [31:0] divisor;
    logic [15:0] tol;
    logic        typed;
    recip_res_t  res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  recip_res_t pending_recips[$];
  recip_res_t want;
  logic [15:0] tol_model = TOL_RESET;
  int err_count = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  q16_reciprocal_newton dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] q16_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b};
    return p[47:16];
  endfunction

  function automatic recip_res_t predict_recip(input logic [31:0] d, input logic [15:0] tol);
    recip_res_t  r;
    logic [31:0] x, prev, t, diff, dn, e, probe, tol32, window;
    int unsigned z, n;
    r.divisor = d;
    r.status  = ST_LIMIT;
    if (d == 32'd0) begin
      r.recip  = 32'hFFFF_FFFF;
      r.iters  = 5'd0;
      r.status = ST_ZERO;
      return r;
    end
    z = 0;
    probe = d;
    while (probe[31] == 1'b0) begin
      probe = probe << 1;
      z++;
    end
    // normalize into [0.5,1), linear seed, scale back
    dn = (z >= 16) ? (d << (z - 16)) : (d >> (16 - z));
    e  = Q_48_OVER_17 - q16_mul(dn, Q_32_OVER_17);
    x  = (z >= 16) ? (e >> (z - 16)) : (e << (16 - z));
    tol32 = {16'b0, tol};
    n = 0;
    while (n < MAX_ITERATIONS) begin
      prev = x;
      t    = Q_TWO - q16_mul(d, prev);
      x    = q16_mul(t, prev);
      diff = x - prev;
      n++;
      window = diff + tol32;
      if (window <= (tol32 << 1)) begin
        r.status = ST_CONV;
        break;
      end
    end
    r.recip = x;
    r.iters = (n > 31) ? 5'd31 : 5'(n);
    return r;
  endfunction

  task automatic send_divisor(input logic [31:0] d, input bit typed, input recip_res_t res);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) pending_recips.push_back(res);
    else pending_recips.push_back(predict_recip(d, tol_model));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_recips.size() != 0);
  endtask

  task automatic write_tolerance(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: short random stalls, one long hold on request
  initial begin : receiver
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 4);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_recips.size() == 0) begin
        err_count++;
        $display("%0t unexpected result: recip %h iters %0d status %0d", $time,
                 out_tdata[31:0], out_tdata[36:32], out_tuser);
      end else begin
        want = pending_recips.pop_front();
        if (out_tdata[31:0] !== want.recip) begin
          err_count++;
          $display("%0t divisor %h reciprocal: expected %h actual %h", $time,
                   want.divisor, want.recip, out_tdata[31:0]);
        end
        if (out_tdata[36:32] !== want.iters) begin
          err_count++;
          $display("%0t divisor %h iterations: expected %0d actual %0d", $time,
                   want.divisor, want.iters, out_tdata[36:32]);
        end
        if (out_tuser !== want.status) begin
          err_count++;
          $display("%0t divisor %h status: expected %0d actual %0d", $time,
                   want.divisor, want.status, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    rows [N_ROWS];
    logic [15:0] phase_tol [N_PHASES];
    recip_res_t  zero_res;
    recip_res_t  none;
    logic [31:0] d;

    zero_res = '{divisor: 32'd0, recip: 32'hFFFF_FFFF, iters: 5'd0, status: ST_ZERO};
    none = '0;
    // the leading tolerance 66 rows rely on the reset value
    rows[0]  = '{32'h0000_0000, TOL_RESET, 1'b1, zero_res};
    rows[1]  = '{32'h0001_0000, TOL_RESET, 1'b0, none};
    rows[2]  = '{32'h0000_0001, TOL_RESET, 1'b0, none};
    rows[3]  = '{32'hFFFF_FFFF, TOL_RESET, 1'b0, none};
    rows[4]  = '{32'h8000_0000, TOL_RESET, 1'b0, none};
    rows[5]  = '{32'h7FFF_FFFF, TOL_RESET, 1'b0, none};
    rows[6]  = '{32'h0000_8000, TOL_RESET, 1'b0, none};
    rows[7]  = '{32'h0002_0000, TOL_RESET, 1'b0, none};
    rows[8]  = '{32'h0000_FFFF, TOL_RESET, 1'b0, none};
    rows[9]  = '{32'h0001_8000, TOL_RESET, 1'b0, none};
    rows[10] = '{32'h1234_5678, TOL_RESET, 1'b0, none};
    rows[11] = '{32'h0003_0000, 16'd0,     1'b0, none};
    rows[12] = '{32'h0000_0003, 16'd0,     1'b0, none};
    rows[13] = '{32'h0000_0000, 16'd0,     1'b1, zero_res};
    rows[14] = '{32'h0001_0000, 16'd0,     1'b0, none};
    rows[15] = '{32'h0001_0000, 16'hFFFF,  1'b0, none};
    rows[16] = '{32'h0005_0000, 16'hFFFF,  1'b0, none};
    rows[17] = '{32'hFFFF_FFFF, 16'hFFFF,  1'b0, none};
    rows[18] = '{32'h0000_0001, 16'hFFFF,  1'b0, none};
    rows[19] = '{32'h0000_0000, 16'hFFFF,  1'b1, zero_res};
    rows[20] = '{32'h0000_7000, 16'd1,     1'b0, none};
    rows[21] = '{32'h0010_0000, TOL_RESET, 1'b0, none};

    phase_tol[0] = 16'hFFFF;
    phase_tol[1] = 16'd0;
    phase_tol[2] = 16'd1;
    phase_tol[3] = 16'($urandom);
    phase_tol[4] = 16'($urandom_range(20, 300));
    phase_tol[5] = TOL_RESET;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].tol != tol_model) begin
        drain_results();
        write_tolerance(rows[i].tol);
      end
      send_divisor(rows[i].divisor, rows[i].typed, rows[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_tolerance(phase_tol[p]);
      if (p == N_PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 50) hold_req = 1'b1;
        if (p == 3 && k == 100) drain_results();
        case ($urandom_range(0, 11))
          0:       d = 32'd0;
          1, 2, 3: d = $urandom() >> $urandom_range(0, 31);
          4:       d = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
          5:       d = $urandom_range(1, 3) == 1 ? 32'hFFFF_FFFF : 32'(($urandom_range(1, 8)));
          default: d = $urandom();
        endcase
        send_divisor(d, 1'b0, none);
      end
    end

    drain_results();
    repeat (100) @(negedge clk);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
design/qrn_pkg.sv
design/qrn_sequencer.sv
design/qrn_datapath.sv
design/q16_reciprocal_newton.sv
tb/sv/q16_reciprocal_newton_tb.sv
